// File: rtl/dro_pkg.sv
// ----------------------------------------------------------------------------
// dro_pkg
// Shared types, constants and helper functions of the dead reckoning
// odometry switch: fixed-point formats, CORDIC constants and FSM codes.
// ----------------------------------------------------------------------------
package dro_pkg;

	// Fraction bits of positions and headings.
	localparam int FRAC = 16;

	// Serial multiplier: wide operand and product width, narrow operand width.
	localparam int PW = 56;
	localparam int MB = 18;

	// CORDIC constants in Q30.
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;

	// Heading wrap modulus, 6.2832 in Q16.
	localparam logic [25:0] HEAD_WRAP = 26'd411776;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SPEED_SCALE = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD_Y = 2'd1;
	localparam logic [1:0] CFG_X_OFFSET    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSTART,
		ST_MWAIT,
		ST_CWAIT,
		ST_WRAP,
		ST_UPDATE,
		ST_HOLD
	} state_t;

	typedef enum logic [2:0] {
		OP_SPD,
		OP_DIST,
		OP_YAW,
		OP_CX,
		OP_SY
	} op_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MOD,
		CS_PI,
		CS_HALF,
		CS_ITER,
		CS_DONE
	} cordic_state_t;

	// Result of the CORDIC unit.
	typedef struct packed {
		logic                    done;
		logic signed [MB-1:0]    cos_v;
		logic signed [MB-1:0]    sin_v;
	} cordic_res_t;

	// Arctangent table in Q30.
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			5'd24: r = 30'd64;
			5'd25: r = 30'd32;
			5'd26: r = 30'd16;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [31:0] r;
		if (v > PW'(64'sd2147483647)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -PW'(64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/dro_if.sv
// ----------------------------------------------------------------------------
// dro_in_if / dro_out_if
// Valid/ready channels that carry the sensor word in and the pose word out.
// ----------------------------------------------------------------------------
interface dro_in_if;
	logic               valid;
	logic               ready;
	logic               right_reverse;
	logic               left_reverse;
	logic [15:0]        right_encoder;
	logic [15:0]        left_encoder;
	logic signed [23:0] yaw_rate;
	logic signed [31:0] visual_x;
	logic signed [31:0] visual_y;
	logic signed [18:0] visual_yaw;
	logic [15:0]        interval;

	modport source (output valid, right_reverse, left_reverse, right_encoder,
		left_encoder, yaw_rate, visual_x, visual_y, visual_yaw, interval,
		input ready);
	modport sink (input valid, right_reverse, left_reverse, right_encoder,
		left_encoder, yaw_rate, visual_x, visual_y, visual_yaw, interval,
		output ready);
endinterface

interface dro_out_if;
	logic               valid;
	logic               ready;
	logic               dead_reckoning;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [19:0] heading;
	logic signed [31:0] step_x;
	logic signed [31:0] step_y;

	modport source (output valid, dead_reckoning, pos_x, pos_y, heading,
		step_x, step_y, input ready);
	modport sink (input valid, dead_reckoning, pos_x, pos_y, heading,
		step_x, step_y, output ready);
endinterface

// File: rtl/dro_serial_mul.sv
// ----------------------------------------------------------------------------
// dro_serial_mul
// Shift-add multiplier: one bit of the narrow signed operand per cycle,
// done pulses for one cycle when the product is ready.
// ----------------------------------------------------------------------------
module dro_serial_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [dro_pkg::PW-1:0]    a,
	input  logic signed [dro_pkg::MB-1:0]    b,
	output logic                             done,
	output logic signed [dro_pkg::PW-1:0]    product
);
	localparam int CW = $clog2(dro_pkg::MB);

	logic                          busy_q;
	logic                          done_q;
	logic [CW-1:0]                 cnt_q;
	logic signed [dro_pkg::PW-1:0] acc_q;
	logic signed [dro_pkg::PW-1:0] a_q;
	logic [dro_pkg::MB-1:0]        b_q;
	logic                          last;

	assign last = (cnt_q == CW'(dro_pkg::MB - 1));

	// Control: bit counter and busy/done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			busy_q <= !last;
			done_q <= last;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: the sign bit of b carries negative weight.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= last ? acc_q - a_q : acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

// File: rtl/dro_cordic.sv
// ----------------------------------------------------------------------------
// dro_cordic
// Rotation-mode CORDIC in Q30: reduces the QF heading into [-pi/2, pi/2]
// in the MOD, PI and HALF states, then runs one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module dro_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [19:0]        angle,
	output dro_pkg::cordic_res_t      res
);
	dro_pkg::cordic_state_t state_q, state_d;
	logic [4:0]             i_q;
	logic signed [34:0]     z_q;
	logic signed [33:0]     x_q;
	logic signed [33:0]     y_q;
	logic                   flip_q;
	logic signed [33:0]     dx;
	logic signed [33:0]     dy;
	logic signed [34:0]     at;
	logic signed [33:0]     xf;
	logic signed [33:0]     yf;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = 35'(dro_pkg::atan_q30(i_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dro_pkg::CS_IDLE: if (start) state_d = dro_pkg::CS_MOD;
			dro_pkg::CS_MOD:  state_d = dro_pkg::CS_PI;
			dro_pkg::CS_PI:   state_d = dro_pkg::CS_HALF;
			dro_pkg::CS_HALF: state_d = dro_pkg::CS_ITER;
			dro_pkg::CS_ITER: begin
				if (i_q == 5'(dro_pkg::CORDIC_STEPS - 1)) state_d = dro_pkg::CS_DONE;
			end
			dro_pkg::CS_DONE: state_d = dro_pkg::CS_IDLE;
			default:          state_d = dro_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dro_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Angle reduction and micro-rotations.
	always_ff @(posedge clk) begin
		unique case (state_q)
			dro_pkg::CS_IDLE: begin
				z_q    <= 35'(angle) <<< 14;
				x_q    <= 34'(dro_pkg::CORDIC_GAIN);
				y_q    <= '0;
				flip_q <= 1'b0;
				i_q    <= '0;
			end
			dro_pkg::CS_MOD: begin
				if (z_q >= dro_pkg::TWO_PI_Q30) begin
					z_q <= z_q - dro_pkg::TWO_PI_Q30;
				end else if (z_q <= -dro_pkg::TWO_PI_Q30) begin
					z_q <= z_q + dro_pkg::TWO_PI_Q30;
				end
			end
			dro_pkg::CS_PI: begin
				if (z_q > dro_pkg::PI_Q30) begin
					z_q <= z_q - dro_pkg::TWO_PI_Q30;
				end else if (z_q < -dro_pkg::PI_Q30) begin
					z_q <= z_q + dro_pkg::TWO_PI_Q30;
				end
			end
			dro_pkg::CS_HALF: begin
				if (z_q > dro_pkg::HALF_PI_Q30) begin
					z_q    <= z_q - dro_pkg::PI_Q30;
					flip_q <= 1'b1;
				end else if (z_q < -dro_pkg::HALF_PI_Q30) begin
					z_q    <= z_q + dro_pkg::PI_Q30;
					flip_q <= 1'b1;
				end
			end
			dro_pkg::CS_ITER: begin
				if (!z_q[34]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Outputs: undo the half-turn and floor to QF.
	always_comb begin
		xf        = flip_q ? -x_q : x_q;
		yf        = flip_q ? -y_q : y_q;
		res.done  = (state_q == dro_pkg::CS_DONE);
		res.cos_v = dro_pkg::MB'(xf >>> (30 - dro_pkg::FRAC));
		res.sin_v = dro_pkg::MB'(yf >>> (30 - dro_pkg::FRAC));
	end
endmodule

// File: rtl/dead_reckoning_odometry_switch.sv
// ----------------------------------------------------------------------------
// dead_reckoning_odometry_switch
// Visual pose pass-through that latches over to wheel/gyro dead reckoning.
// ----------------------------------------------------------------------------
// Usage:
// One sensor word enters on in_ch per loop tick; one pose word leaves on
// out_ch for each. Registers are to be written by the user through
// cfg_we/cfg_index/cfg_wdata while the block is idle; the block does not enforce it.
// Until visual y falls below the threshold, the word is the visual pose with
// x shifted by the offset, loaded from the HOLD state into the output register.
// In dead reckoning the shared bit-serial multiplier forms five products
// (speed, distance, yaw increment, x and y step), while the CORDIC unit
// works the old heading in parallel; a remainder step then wraps the heading.
// One item is processed at a time. in_ch.ready is high whenever the
// sequencer is idle, even while a finished word waits in the output
// register; a stalled receiver holds the next word at the end of its work.
// Reset clears the latch and the estimate and loads the default registers.
// ----------------------------------------------------------------------------
module dead_reckoning_odometry_switch (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	dro_in_if.sink             in_ch,
	dro_out_if.source          out_ch
);
	dro_pkg::state_t state_q, state_d;
	dro_pkg::op_t    op_q, op_d;

	// Configuration.
	logic [15:0]        speed_scale_q;
	logic signed [31:0] threshold_y_q;
	logic signed [31:0] x_offset_q;

	// Item and estimate.
	logic               rrev_q, lrev_q;
	logic [15:0]        renc_q, lenc_q, ivl_q;
	logic signed [23:0] yaw_q;
	logic signed [31:0] vx_q, vy_q;
	logic signed [18:0] vyaw_q;
	logic               latched_q, latched_d;
	logic signed [31:0] est_x_q, est_y_q;
	logic signed [19:0] est_h_q;

	// Working values.
	logic signed [34:0] sum_q;
	logic signed [26:0] dist_q;
	logic [25:0]        mag_q;
	logic               hneg_q;
	logic [2:0]         wcnt_q;
	logic signed [31:0] sx_q, sy_q;
	logic signed [dro_pkg::MB-1:0] cos_q, sin_q;
	logic               cdone_q;
	logic               out_valid_q;

	logic                          accept, out_load, mul_start, cordic_start;
	logic signed [dro_pkg::PW-1:0] mul_a, mul_p;
	logic signed [dro_pkg::MB-1:0] mul_b;
	logic                          mul_done;
	dro_pkg::cordic_res_t          cres;
	logic signed [17:0]            spd;
	logic signed [25:0]            th;
	logic [25:0]                   wstep;

	assign accept = in_ch.valid && in_ch.ready;
	assign latched_d = latched_q || (in_ch.visual_y < threshold_y_q);

	// Signed wheel speed sum, before scaling.
	assign spd = (rrev_q ? -18'(renc_q) : 18'(renc_q))
		+ (lrev_q ? -18'(lenc_q) : 18'(lenc_q));
	assign th = 26'(est_h_q) + 26'(mul_p >>> 16);
	assign wstep = dro_pkg::HEAD_WRAP << wcnt_q;

	// Multiplier operand selection.
	always_comb begin
		unique case (op_q)
			dro_pkg::OP_SPD: begin
				mul_a = dro_pkg::PW'(spd);
				mul_b = dro_pkg::MB'(speed_scale_q);
			end
			dro_pkg::OP_DIST: begin
				mul_a = dro_pkg::PW'(sum_q);
				mul_b = dro_pkg::MB'(ivl_q);
			end
			dro_pkg::OP_YAW: begin
				mul_a = dro_pkg::PW'(yaw_q);
				mul_b = dro_pkg::MB'(ivl_q);
			end
			dro_pkg::OP_CX: begin
				mul_a = dro_pkg::PW'(dist_q);
				mul_b = cos_q;
			end
			dro_pkg::OP_SY: begin
				mul_a = dro_pkg::PW'(dist_q);
				mul_b = sin_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dro_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	dro_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (est_h_q),
		.res    (cres)
	);

	// Next state and operation.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			dro_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					if (latched_d) begin
						state_d = dro_pkg::ST_MSTART;
						op_d    = dro_pkg::OP_SPD;
					end else begin
						state_d = dro_pkg::ST_HOLD;
					end
				end
			end
			dro_pkg::ST_MSTART: state_d = dro_pkg::ST_MWAIT;
			dro_pkg::ST_MWAIT: begin
				if (mul_done) begin
					unique case (op_q)
						dro_pkg::OP_SPD: begin
							state_d = dro_pkg::ST_MSTART;
							op_d    = dro_pkg::OP_DIST;
						end
						dro_pkg::OP_DIST: begin
							state_d = dro_pkg::ST_MSTART;
							op_d    = dro_pkg::OP_YAW;
						end
						dro_pkg::OP_YAW: begin
							state_d = dro_pkg::ST_CWAIT;
							op_d    = dro_pkg::OP_CX;
						end
						dro_pkg::OP_CX: begin
							state_d = dro_pkg::ST_MSTART;
							op_d    = dro_pkg::OP_SY;
						end
						dro_pkg::OP_SY: state_d = dro_pkg::ST_WRAP;
						default:        state_d = dro_pkg::ST_IDLE;
					endcase
				end
			end
			dro_pkg::ST_CWAIT: if (cdone_q) state_d = dro_pkg::ST_MSTART;
			dro_pkg::ST_WRAP:  if (wcnt_q == 3'd0) state_d = dro_pkg::ST_UPDATE;
			dro_pkg::ST_UPDATE: state_d = dro_pkg::ST_HOLD;
			dro_pkg::ST_HOLD: if (!out_valid_q || out_ch.ready) state_d = dro_pkg::ST_IDLE;
			default: state_d = dro_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ch.ready  = (state_q == dro_pkg::ST_IDLE);
		mul_start    = (state_q == dro_pkg::ST_MSTART);
		cordic_start = accept && latched_d;
		out_load     = (state_q == dro_pkg::ST_HOLD) && (!out_valid_q || out_ch.ready);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dro_pkg::ST_IDLE;
			op_q          <= dro_pkg::OP_SPD;
			speed_scale_q <= 16'd721;
			threshold_y_q <= -32'sd589824;
			x_offset_q    <= 32'sd18022;
			latched_q     <= 1'b0;
			est_x_q       <= '0;
			est_y_q       <= '0;
			est_h_q       <= '0;
			cdone_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cfg_we) begin
				unique case (cfg_index)
					dro_pkg::CFG_SPEED_SCALE: speed_scale_q <= cfg_wdata[15:0];
					dro_pkg::CFG_THRESHOLD_Y: threshold_y_q <= cfg_wdata;
					dro_pkg::CFG_X_OFFSET:    x_offset_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				latched_q <= latched_d;
				if (!latched_d) begin
					est_x_q <= in_ch.visual_x;
					est_y_q <= in_ch.visual_y;
					est_h_q <= 20'(in_ch.visual_yaw);
				end
			end
			if (state_q == dro_pkg::ST_UPDATE) begin
				est_x_q <= dro_pkg::sat32(dro_pkg::PW'(est_x_q) + dro_pkg::PW'(sx_q));
				est_y_q <= dro_pkg::sat32(dro_pkg::PW'(est_y_q) + dro_pkg::PW'(sy_q));
				est_h_q <= hneg_q ? -20'(mag_q) : 20'(mag_q);
			end
			if (cordic_start) begin
				cdone_q <= 1'b0;
			end else if (cres.done) begin
				cdone_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, product capture and heading remainder.
	always_ff @(posedge clk) begin
		if (accept) begin
			rrev_q <= in_ch.right_reverse;
			lrev_q <= in_ch.left_reverse;
			renc_q <= in_ch.right_encoder;
			lenc_q <= in_ch.left_encoder;
			yaw_q  <= in_ch.yaw_rate;
			vx_q   <= in_ch.visual_x;
			vy_q   <= in_ch.visual_y;
			vyaw_q <= in_ch.visual_yaw;
			ivl_q  <= in_ch.interval;
		end
		if (cres.done) begin
			cos_q <= cres.cos_v;
			sin_q <= cres.sin_v;
		end
		if (state_q == dro_pkg::ST_MWAIT && mul_done) begin
			unique case (op_q)
				dro_pkg::OP_SPD:  sum_q  <= 35'(mul_p);
				dro_pkg::OP_DIST: dist_q <= 27'(mul_p >>> (41 - dro_pkg::FRAC));
				dro_pkg::OP_YAW: begin
					hneg_q <= th[25];
					mag_q  <= th[25] ? 26'(-th) : 26'(th);
					wcnt_q <= 3'd6;
				end
				dro_pkg::OP_CX:   sx_q <= dro_pkg::sat32(mul_p >>> dro_pkg::FRAC);
				dro_pkg::OP_SY:   sy_q <= dro_pkg::sat32(mul_p >>> dro_pkg::FRAC);
				default: ;
			endcase
		end
		// One quotient bit per cycle of the magnitude remainder.
		if (state_q == dro_pkg::ST_WRAP) begin
			if (mag_q >= wstep) begin
				mag_q <= mag_q - wstep;
			end
			wcnt_q <= wcnt_q - 1'b1;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.dead_reckoning <= latched_q;
			if (latched_q) begin
				out_ch.pos_x   <= est_x_q;
				out_ch.pos_y   <= est_y_q;
				out_ch.heading <= est_h_q;
				out_ch.step_x  <= sx_q;
				out_ch.step_y  <= sy_q;
			end else begin
				out_ch.pos_x   <= dro_pkg::sat32(dro_pkg::PW'(vx_q) - dro_pkg::PW'(x_offset_q));
				out_ch.pos_y   <= vy_q;
				out_ch.heading <= 20'(vyaw_q);
				out_ch.step_x  <= '0;
				out_ch.step_y  <= '0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
endmodule

// File: rtl/dro_checker.sv
// ----------------------------------------------------------------------------
// dro_props
// Port-level checks of the odometry switch, bound to the top level.
// ----------------------------------------------------------------------------
module dro_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_dr,
	input logic signed [31:0] out_pos_x,
	input logic signed [31:0] out_step_x,
	input logic signed [31:0] out_step_y
);
	logic seen_dr_q;

	// Remembers that a dead-reckoned word has been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_dr_q <= 1'b0;
		end else if (out_valid && out_ready && out_dr) begin
			seen_dr_q <= 1'b1;
		end
	end

	// A stalled word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled word keeps its x position.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pos_x))
		else $error("output word changed while stalled");

	// The block takes one word at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// Once dead reckoning shows, it never goes back.
	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_dr_q |-> out_dr)
		else $error("dead reckoning flag fell");

	// Visual words carry no step.
	a_visual_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_dr |-> (out_step_x == 32'sd0) && (out_step_y == 32'sd0))
		else $error("nonzero step in visual mode");
endmodule

bind dead_reckoning_odometry_switch dro_props u_dro_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_dr     (out_ch.dead_reckoning),
	.out_pos_x  (out_ch.pos_x),
	.out_step_x (out_ch.step_x),
	.out_step_y (out_ch.step_y)
);

// File: dv/dro_checker.sv
// ----------------------------------------------------------------------------
// dro_checker
// Watches the configuration port and both channels of the dead reckoning
// odometry switch. It predicts each pose word from every accepted sensor word
// and compares the pose words that leave the block against those predictions,
// in order and field by field.
// ----------------------------------------------------------------------------
module dro_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	dro_in_if           in_ch,
	dro_out_if          out_ch,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               dead_reckoning;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [19:0] heading;
		logic signed [31:0] step_x;
		logic signed [31:0] step_y;
	} pose_t;

	localparam longint ATAN_Q30 [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64,
		32, 16, 8, 4, 2};
	localparam longint GAIN = 652032874;
	localparam longint PI30 = 64'sd3373259426;
	localparam longint HALF_PI30 = 64'sd1686629713;
	localparam longint TWO_PI30 = 64'sd6746518852;
	localparam longint WRAP30 = 64'sd6746534629;

	// Mirror of the registers and of the pose estimate.
	logic [15:0]        speed_scale;
	logic signed [31:0] threshold_y;
	logic signed [31:0] x_offset;
	logic               latched;
	longint             est_x;
	longint             est_y;
	longint             est_heading;

	pose_t expected_poses[$];

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Rotation-mode CORDIC of the heading, results in Q16.
	function automatic void heading_cos_sin(input longint ang, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = (ang * 16384) % TWO_PI30;
		x = GAIN;
		y = 0;
		flip = 0;
		if (z > PI30) begin
			z -= TWO_PI30;
		end else if (z < -PI30) begin
			z += TWO_PI30;
		end
		if (z > HALF_PI30) begin
			z -= PI30;
			flip = 1;
		end else if (z < -HALF_PI30) begin
			z += PI30;
			flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_Q30[i];
			end else begin
				x += dx; y -= dy; z += ATAN_Q30[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x >>> 14;
		s = y >>> 14;
	endfunction

	// Works out the pose word for one sensor word and advances the estimate.
	function automatic pose_t next_pose();
		pose_t  p;
		longint rs, ls, travel, c, s, sx, sy, th, wrap;
		if (longint'(in_ch.visual_y) < longint'(threshold_y)) begin
			latched = 1'b1;
		end
		p = '0;
		p.dead_reckoning = latched;
		if (!latched) begin
			p.pos_x = 32'(clamp32(longint'(in_ch.visual_x) - longint'(x_offset)));
			p.pos_y = in_ch.visual_y;
			p.heading = 20'(longint'(in_ch.visual_yaw));
			est_x = in_ch.visual_x;
			est_y = in_ch.visual_y;
			est_heading = in_ch.visual_yaw;
		end else begin
			rs = longint'(in_ch.right_encoder) * longint'(speed_scale);
			ls = longint'(in_ch.left_encoder) * longint'(speed_scale);
			if (in_ch.right_reverse) begin
				rs = -rs;
			end
			if (in_ch.left_reverse) begin
				ls = -ls;
			end
			travel = ((rs + ls) * longint'(in_ch.interval)) >>> 25;
			heading_cos_sin(est_heading, c, s);
			sx = clamp32((travel * c) >>> 16);
			sy = clamp32((travel * s) >>> 16);
			est_x = clamp32(est_x + sx);
			est_y = clamp32(est_y + sy);
			th = est_heading +
				((longint'(in_ch.yaw_rate) * longint'(in_ch.interval)) >>> 16);
			wrap = (WRAP30 + 8192) >>> 14;
			est_heading = th % wrap;
			p.pos_x = 32'(est_x);
			p.pos_y = 32'(est_y);
			p.heading = 20'(est_heading);
			p.step_x = 32'(sx);
			p.step_y = 32'(sy);
		end
		return p;
	endfunction

	// Register writes, predictions and comparisons, all sampled at the edge.
	always @(posedge clk or negedge arst_n) begin
		pose_t got, want;
		if (!arst_n) begin
			speed_scale <= 16'd721;
			threshold_y <= -32'sd589824;
			x_offset <= 32'sd18022;
			latched = 1'b0;
			est_x = 0;
			est_y = 0;
			est_heading = 0;
			mismatches <= 0;
			expected_poses.delete();
			pending <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_poses.push_back(next_pose());
			end
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.dead_reckoning, out_ch.pos_x, out_ch.pos_y,
					out_ch.heading, out_ch.step_x, out_ch.step_y};
				if (expected_poses.size() == 0) begin
					$display("%t: unexpected pose word %h", $realtime, got);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_poses.pop_front();
					if (got !== want) begin
						$display("%t: pose mismatch expected dr=%0d x=%0d y=%0d h=%0d sx=%0d sy=%0d",
							$realtime, want.dead_reckoning, want.pos_x, want.pos_y,
							want.heading, want.step_x, want.step_y);
						$display("%t:                actual dr=%0d x=%0d y=%0d h=%0d sx=%0d sy=%0d",
							$realtime, got.dead_reckoning, got.pos_x, got.pos_y,
							got.heading, got.step_x, got.step_y);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_poses.size();
			// A write lands after this edge's word has been predicted.
			if (cfg_we) begin
				case (cfg_index)
					dro_pkg::CFG_SPEED_SCALE: speed_scale <= cfg_wdata[15:0];
					dro_pkg::CFG_THRESHOLD_Y: threshold_y <= cfg_wdata;
					dro_pkg::CFG_X_OFFSET:    x_offset <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the dead reckoning odometry switch. Visual words come first
// under several offsets with the switch held off, then the threshold is armed
// and crossed, then many dead reckoning words run under several speed scales.
// Both sides idle at random; the checker module judges every pose word.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic               rrev;
		logic               lrev;
		logic [15:0]        renc;
		logic [15:0]        lenc;
		logic signed [23:0] yaw;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [18:0] vyaw;
		logic [15:0]        ivl;
	} sensor_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;
	int          mismatches;
	int          pending;
	bit          calm;

	dro_in_if  in_ch ();
	dro_out_if out_ch ();

	dead_reckoning_odometry_switch dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch));

	dro_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
		.mismatches(mismatches), .pending(pending));

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic int pause();
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	// Random value of up to 32 bits, often at an extreme.
	function automatic logic [31:0] edgy(input int w);
		logic [31:0] mask;
		mask = (w == 32) ? 32'hFFFFFFFF : (32'h1 << w) - 1;
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return mask;
			2: return mask >> 1;
			3: return ~(mask >> 1) & mask;
			default: return $urandom() & mask;
		endcase
	endfunction

	function automatic sensor_t any_word();
		sensor_t w;
		w.rrev = $urandom_range(0, 1);
		w.lrev = $urandom_range(0, 1);
		w.renc = edgy(16);
		w.lenc = edgy(16);
		w.yaw = edgy(24);
		w.vx = edgy(32);
		w.vy = edgy(32);
		w.vyaw = $urandom_range(0, 411774) - 205887;
		w.ivl = edgy(16);
		return w;
	endfunction

	task automatic send(input sensor_t w);
		int gap;
		gap = pause();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.right_reverse <= w.rrev;
		in_ch.left_reverse <= w.lrev;
		in_ch.right_encoder <= w.renc;
		in_ch.left_encoder <= w.lenc;
		in_ch.yaw_rate <= w.yaw;
		in_ch.visual_x <= w.vx;
		in_ch.visual_y <= w.vy;
		in_ch.visual_yaw <= w.vyaw;
		in_ch.interval <= w.ivl;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Lets the block drain, then writes one register.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver stalls for a random number of cycles before each word.
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pause();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		sensor_t w;
		arst_n = 1'b0;
		calm = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dro_pkg::CFG_SPEED_SCALE;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.right_reverse = 1'b0;
		in_ch.left_reverse = 1'b0;
		in_ch.right_encoder = '0;
		in_ch.left_encoder = '0;
		in_ch.yaw_rate = '0;
		in_ch.visual_x = '0;
		in_ch.visual_y = '0;
		in_ch.visual_yaw = '0;
		in_ch.interval = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Visual pass-through with the switch disarmed and offset extremes.
		write_reg(dro_pkg::CFG_THRESHOLD_Y, 32'h80000000);
		write_reg(dro_pkg::CFG_X_OFFSET, 32'h7FFFFFFF);
		w = any_word();
		w.vx = 32'h80000000; w.vyaw = -19'sd205887;
		send(w);
		w.vx = 32'h7FFFFFFF; w.vyaw = 19'sd205887;
		send(w);
		for (int i = 0; i < 40; i++) send(any_word());
		write_reg(dro_pkg::CFG_X_OFFSET, 32'h80000000);
		w.vx = 32'h7FFFFFFF;
		send(w);
		w.vx = 32'h80000000;
		send(w);
		for (int i = 0; i < 40; i++) send(any_word());
		write_reg(dro_pkg::CFG_X_OFFSET, 32'sd18022);

		// Arm the switch: equal to the threshold stays visual, below latches.
		write_reg(dro_pkg::CFG_THRESHOLD_Y, -32'sd589824);
		for (int i = 0; i < 20; i++) begin
			w = any_word();
			w.vy = $urandom_range(0, 32'h7FFFFFFF);
			send(w);
		end
		w.vy = -32'sd589824;
		send(w);
		w.vy = -32'sd589825;
		w.renc = 16'hFFFF; w.lenc = 16'hFFFF; w.ivl = 16'hFFFF;
		w.rrev = 1'b0; w.lrev = 1'b0; w.yaw = 24'sh7FFFFF;
		send(w);
		w.vy = 32'h7FFFFFFF;
		send(w);
		w.rrev = 1'b1; w.lrev = 1'b1; w.yaw = 24'sh800000;
		send(w); send(w); send(w);
		w.rrev = 1'b1; w.lrev = 1'b0;
		send(w);
		w.ivl = 16'h0;
		send(w);

		// Dead reckoning under several speed scales, extremes included.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_reg(dro_pkg::CFG_SPEED_SCALE, 16'hFFFF);
				1: write_reg(dro_pkg::CFG_SPEED_SCALE, 16'h0000);
				2: write_reg(dro_pkg::CFG_SPEED_SCALE, $urandom());
				default: write_reg(dro_pkg::CFG_SPEED_SCALE, 16'd721);
			endcase
			for (int i = 0; i < 320; i++) begin
				if ($urandom_range(0, 59) == 0) begin
					calm = !calm;
				end
				send(any_word());
			end
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
